// ===== sv/bgr_pkg.sv =====
`default_nettype none
package bgr_pkg;

   localparam int COORD_BITS = 12;
   localparam int CH_BITS    = 8;
   localparam int LANES      = 3;
   localparam int NUM_BITS   = CH_BITS + COORD_BITS;
   localparam int DIV_STEPS  = CH_BITS;
   localparam int SHIFT_BITS = $clog2(CH_BITS);
   localparam int CSR_BITS   = 3;
   localparam int COLOR_BITS = LANES * CH_BITS;

   typedef logic [COORD_BITS-1:0]             coord_type;
   typedef logic [LANES-1:0][CH_BITS-1:0]     color_type;
   typedef logic [LANES-1:0][NUM_BITS-1:0]    num_type;
   typedef logic [CSR_BITS-1:0]               csr_index_type;
   typedef logic [SHIFT_BITS-1:0]             shift_type;

   localparam csr_index_type CSR_X_RES        = 3'd0;
   localparam csr_index_type CSR_Y_RES        = 3'd1;
   localparam csr_index_type CSR_TOP_LEFT     = 3'd2;
   localparam csr_index_type CSR_TOP_RIGHT    = 3'd3;
   localparam csr_index_type CSR_BOTTOM_LEFT  = 3'd4;
   localparam csr_index_type CSR_BOTTOM_RIGHT = 3'd5;

   localparam coord_type X_RES_RESET        = COORD_BITS'(640);
   localparam coord_type Y_RES_RESET        = COORD_BITS'(480);
   localparam color_type TOP_LEFT_RESET     = 24'h0000FF;
   localparam color_type TOP_RIGHT_RESET    = 24'h00FF00;
   localparam color_type BOTTOM_LEFT_RESET  = 24'hFF0000;
   localparam color_type BOTTOM_RIGHT_RESET = 24'hFFFF00;

   // Treat a zero resolution as one
   function automatic coord_type nonzero(input coord_type d);
      return (d == '0) ? COORD_BITS'(1) : d;
   endfunction

endpackage
`default_nettype wire

// ===== sv/bgr_mix.sv =====
`default_nettype none
module bgr_mix (
   input  wire logic               clock,
   input  wire logic               enable,
   input  wire bgr_pkg::coord_type pos,
   input  wire bgr_pkg::coord_type divisor,
   input  wire bgr_pkg::color_type color_a,
   input  wire bgr_pkg::color_type color_b,
   output bgr_pkg::num_type        num_ff
);

   bgr_pkg::num_type num_in;

   // Weight both colors per channel: a*(d-p) + b*p
   always_comb begin
      for (int i = 0; i < bgr_pkg::LANES; i++) begin
         num_in[i] = bgr_pkg::NUM_BITS'(color_a[i]) * bgr_pkg::NUM_BITS'(divisor - pos)
                   + bgr_pkg::NUM_BITS'(color_b[i]) * bgr_pkg::NUM_BITS'(pos);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         num_ff <= num_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/bgr_div_step.sv =====
`default_nettype none
module bgr_div_step (
   input  wire logic               clock,
   input  wire logic               enable,
   input  wire bgr_pkg::coord_type divisor,
   input  wire bgr_pkg::shift_type shift,
   input  wire bgr_pkg::num_type   rem,
   input  wire bgr_pkg::color_type quo,
   output bgr_pkg::num_type        rem_ff,
   output bgr_pkg::color_type      quo_ff
);

   bgr_pkg::num_type   rem_in;
   bgr_pkg::color_type quo_in;
   logic [bgr_pkg::NUM_BITS-1:0] dsh;

   // One restoring step: subtract the shifted divisor where it fits
   always_comb begin
      dsh = bgr_pkg::NUM_BITS'(divisor) << shift;
      for (int i = 0; i < bgr_pkg::LANES; i++) begin
         if (rem[i] >= dsh) begin
            rem_in[i] = rem[i] - dsh;
            quo_in[i] = quo[i] | (bgr_pkg::CH_BITS'(1) << shift);
         end else begin
            rem_in[i] = rem[i];
            quo_in[i] = quo[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/bilinear_rgb_gradient.sv =====
`default_nettype none
// Channel   Direction  Handshake        Payload
// req       in         valid / stall    x_pos, y_pos (12 bits each)
// rsp       out        valid / stall    pixel_color (24 bits)
// csr       in         valid / ready    index (3 bits), data (24 bits)
//
// One pixel per cycle unless rsp stalls; the pipeline is a clamp stage, then
// per direction one multiply stage and eight restoring divider steps.
// Synchronous reset clears the stage valid bits and restores the CSRs.
// Each stage holds only while it is full and the one after it holds, so
// bubbles close up under rsp stall and nothing is lost or repeated.
module bilinear_rgb_gradient (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire bgr_pkg::coord_type      req_x_pos,
   input  wire bgr_pkg::coord_type      req_y_pos,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [bgr_pkg::COLOR_BITS-1:0] rsp_pixel_color,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire bgr_pkg::csr_index_type  csr_index,
   input  wire logic [bgr_pkg::COLOR_BITS-1:0] csr_data
);

   localparam int DS         = bgr_pkg::DIV_STEPS;
   localparam int VMIX       = DS + 2;
   localparam int LAST       = 2 * DS + 2;
   localparam int NUM_STAGES = LAST + 1;

   bgr_pkg::coord_type x_res_ff, y_res_ff;
   bgr_pkg::color_type tl_ff, tr_ff, bl_ff, br_ff;
   bgr_pkg::coord_type wdiv, hdiv;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES:0]   ready;

   bgr_pkg::coord_type px_ff, px_in;
   bgr_pkg::coord_type py_ff [VMIX];
   bgr_pkg::coord_type py_in;

   bgr_pkg::num_type   t_rem [DS+1];
   bgr_pkg::color_type t_quo [DS+1];
   bgr_pkg::num_type   b_rem [DS+1];
   bgr_pkg::color_type b_quo [DS+1];
   bgr_pkg::num_type   v_rem [DS+1];
   bgr_pkg::color_type v_quo [DS+1];

   // Accept configuration writes at any time
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_res_ff <= bgr_pkg::X_RES_RESET;
         y_res_ff <= bgr_pkg::Y_RES_RESET;
         tl_ff    <= bgr_pkg::TOP_LEFT_RESET;
         tr_ff    <= bgr_pkg::TOP_RIGHT_RESET;
         bl_ff    <= bgr_pkg::BOTTOM_LEFT_RESET;
         br_ff    <= bgr_pkg::BOTTOM_RIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            bgr_pkg::CSR_X_RES:        x_res_ff <= csr_data[bgr_pkg::COORD_BITS-1:0];
            bgr_pkg::CSR_Y_RES:        y_res_ff <= csr_data[bgr_pkg::COORD_BITS-1:0];
            bgr_pkg::CSR_TOP_LEFT:     tl_ff    <= csr_data;
            bgr_pkg::CSR_TOP_RIGHT:    tr_ff    <= csr_data;
            bgr_pkg::CSR_BOTTOM_LEFT:  bl_ff    <= csr_data;
            bgr_pkg::CSR_BOTTOM_RIGHT: br_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign wdiv = bgr_pkg::nonzero(x_res_ff);
   assign hdiv = bgr_pkg::nonzero(y_res_ff);

   // Advance a stage when it is empty or the next stage advances
   always_comb begin
      ready[NUM_STAGES] = !rsp_stall;
      for (int s = NUM_STAGES - 1; s >= 0; s--) begin
         ready[s] = !valid_ff[s] || ready[s+1];
      end
   end

   assign req_stall = !ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int s = 1; s < NUM_STAGES; s++) begin
            if (ready[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   // Clamp coordinates to the resolution
   assign px_in = (req_x_pos > wdiv) ? wdiv : req_x_pos;
   assign py_in = (req_y_pos > hdiv) ? hdiv : req_y_pos;

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         px_ff    <= px_in;
         py_ff[0] <= py_in;
      end
      for (int s = 1; s < VMIX; s++) begin
         if (ready[s]) begin
            py_ff[s] <= py_ff[s-1];
         end
      end
   end

   // Horizontal blend along top and bottom edges
   bgr_mix u_mix_top (
      .clock   (clock),
      .enable  (ready[1]),
      .pos     (px_ff),
      .divisor (wdiv),
      .color_a (tl_ff),
      .color_b (tr_ff),
      .num_ff  (t_rem[0])
   );

   bgr_mix u_mix_bot (
      .clock   (clock),
      .enable  (ready[1]),
      .pos     (px_ff),
      .divisor (wdiv),
      .color_a (bl_ff),
      .color_b (br_ff),
      .num_ff  (b_rem[0])
   );

   assign t_quo[0] = '0;
   assign b_quo[0] = '0;

   for (genvar k = 0; k < DS; k++) begin : g_hdiv
      bgr_div_step u_top (
         .clock   (clock),
         .enable  (ready[2+k]),
         .divisor (wdiv),
         .shift   (bgr_pkg::SHIFT_BITS'(DS - 1 - k)),
         .rem     (t_rem[k]),
         .quo     (t_quo[k]),
         .rem_ff  (t_rem[k+1]),
         .quo_ff  (t_quo[k+1])
      );
      bgr_div_step u_bot (
         .clock   (clock),
         .enable  (ready[2+k]),
         .divisor (wdiv),
         .shift   (bgr_pkg::SHIFT_BITS'(DS - 1 - k)),
         .rem     (b_rem[k]),
         .quo     (b_quo[k]),
         .rem_ff  (b_rem[k+1]),
         .quo_ff  (b_quo[k+1])
      );
   end

   // Vertical blend between the top and bottom edge results
   bgr_mix u_mix_vert (
      .clock   (clock),
      .enable  (ready[VMIX]),
      .pos     (py_ff[VMIX-1]),
      .divisor (hdiv),
      .color_a (t_quo[DS]),
      .color_b (b_quo[DS]),
      .num_ff  (v_rem[0])
   );

   assign v_quo[0] = '0;

   for (genvar k = 0; k < DS; k++) begin : g_vdiv
      bgr_div_step u_vert (
         .clock   (clock),
         .enable  (ready[VMIX+1+k]),
         .divisor (hdiv),
         .shift   (bgr_pkg::SHIFT_BITS'(DS - 1 - k)),
         .rem     (v_rem[k]),
         .quo     (v_quo[k]),
         .rem_ff  (v_rem[k+1]),
         .quo_ff  (v_quo[k+1])
      );
   end

   assign rsp_valid       = valid_ff[LAST];
   assign rsp_pixel_color = v_quo[DS];

endmodule
`default_nettype wire
